// ===== rtl/rpcd_pkg.sv =====
package rpcd_pkg;

  localparam int PAIR_SLOTS_DEF = 24;

  localparam int SUM_W     = 21;
  localparam int MEAN_W    = 17;
  localparam int CMP_W     = 18;
  localparam int BIT_IDX_W = 5;
  localparam int CNT_W     = 6;
  localparam int CODE_W    = 24;
  localparam int CFG_W     = 16;

  localparam logic [CNT_W-1:0]     LONG_PAIRS  = 6'd32;
  localparam logic [CNT_W-1:0]     SHORT_PAIRS = 6'd25;
  localparam logic [CNT_W-1:0]     COUNT_MAX   = 6'd63;
  localparam logic [BIT_IDX_W-1:0] LONG_BITS   = 5'd23;
  localparam logic [BIT_IDX_W-1:0] SHORT_BITS  = 5'd24;

  // mean = (sum * ceil(2^26 / bits)) >> 26, exact for any 21-bit sum
  localparam int RECIP_W     = 22;
  localparam int RECIP_SHIFT = 26;
  localparam int PROD_W      = SUM_W + RECIP_W;
  localparam logic [RECIP_W-1:0] RECIP_LONG  = 22'd2917777;
  localparam logic [RECIP_W-1:0] RECIP_SHORT = 22'd2796203;

  localparam logic [14:0] TOL_RESET = 15'd500;
  localparam logic [15:0] REL_RESET = 16'd100;

  localparam logic REG_TOLERANCE = 1'b0;
  localparam logic REG_RELEASE   = 1'b1;

  typedef struct packed {
    logic        op;
    logic        first_level;
    logic [14:0] first_time;
    logic        second_level;
    logic [14:0] second_time;
    logic        frame_end;
  } in_word_t;

  typedef struct packed {
    logic [CODE_W-1:0] code;
    logic              is_release;
  } out_word_t;

endpackage

// ===== rtl/remote_pulse_code_decoder.sv =====
// Channel  | Ports                               | Handshake
// ---------+-------------------------------------+------------------------------
// input    | start, busy, in_word                | taken when start && !busy
// result   | out_valid, out_word                 | one-cycle strobe, no stall
// config   | cfg_we, cfg_index, cfg_data         | written when cfg_we is high
//
// A tick, a pair that does not end a frame or a frame end of wrong length leaves
// busy low. A judged frame end holds busy while the pair memory's single read port
// is walked twice (sum, then check) with a reciprocal multiply for the mean between;
// a bad pair cuts the check walk short. Reset is synchronous; the pair memory is
// not cleared, only written entries of the current frame are read. The receiver
// cannot stall; a code leaves as busy falls.
module remote_pulse_code_decoder
  import rpcd_pkg::*;
#(
  parameter int PAIR_SLOTS = PAIR_SLOTS_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  output logic             busy,
  input  in_word_t         in_word,
  output logic             out_valid,
  output out_word_t        out_word,
  input  logic             cfg_we,
  input  logic             cfg_index,
  input  logic [CFG_W-1:0] cfg_data
);

  localparam int AW = $clog2(PAIR_SLOTS);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_SUM   = 3'd1;
  localparam logic [2:0] ST_DIV   = 3'd2;
  localparam logic [2:0] ST_CHECK = 3'd3;
  localparam logic [2:0] ST_DONE  = 3'd4;

  logic [31:0] mem [PAIR_SLOTS];
  logic [31:0] rd_data_r;
  logic        wr_en;
  logic        rd_en;

  logic [2:0]           state_r, state_nxt;
  logic [CNT_W-1:0]     pair_cnt_r, pair_cnt_nxt;
  logic [CODE_W-1:0]    prev_code_r, prev_code_nxt;
  logic [15:0]          countdown_r, countdown_nxt;
  logic [14:0]          tol_r, tol_nxt;
  logic [15:0]          rel_r, rel_nxt;
  logic [BIT_IDX_W-1:0] bits_r, bits_nxt;
  logic [BIT_IDX_W-1:0] idx_r, idx_nxt;
  logic                 rd_vld_r, rd_vld_nxt;
  logic [SUM_W-1:0]     sum_r, sum_nxt;
  logic [MEAN_W-1:0]    mean_r, mean_nxt;
  logic [CODE_W-1:0]    acc_r, acc_nxt;
  logic                 out_valid_r, out_valid_nxt;
  out_word_t            out_word_r, out_word_nxt;

  logic [CNT_W-1:0]     count_new;
  logic [15:0]          pair_t;
  logic [15:0]          pair_hi;
  logic [CMP_W-1:0]     t_ext, tol_ext, mean_ext;
  logic                 pair_bad;
  logic                 pair_bit;
  logic [RECIP_W-1:0]   recip;
  logic [PROD_W-1:0]    mean_prod;

  assign wr_en = (state_r == ST_IDLE) && start && !in_word.op
                 && (pair_cnt_r < CNT_W'(PAIR_SLOTS));
  assign rd_en = ((state_r == ST_SUM) || (state_r == ST_CHECK)) && (idx_r < bits_r);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[pair_cnt_r[AW-1:0]] <= {in_word.first_level, in_word.first_time,
                                  in_word.second_level, in_word.second_time};
    end
    if (rd_en) begin
      rd_data_r <= mem[idx_r[AW-1:0]];
    end
  end

  assign count_new = (pair_cnt_r < COUNT_MAX) ? pair_cnt_r + 1'b1 : pair_cnt_r;
  assign pair_hi   = {1'b0, rd_data_r[30:16]};
  assign pair_t    = pair_hi + {1'b0, rd_data_r[14:0]};
  assign t_ext     = CMP_W'(pair_t);
  assign tol_ext   = CMP_W'(tol_r);
  assign mean_ext  = CMP_W'(mean_r);
  assign pair_bad  = (t_ext + tol_ext < mean_ext) || (t_ext > mean_ext + tol_ext)
                     || !rd_data_r[31] || rd_data_r[15];
  assign pair_bit  = MEAN_W'(pair_hi) > (mean_r >> 1);
  assign recip     = (bits_r == LONG_BITS) ? RECIP_LONG : RECIP_SHORT;
  assign mean_prod = PROD_W'(sum_r) * PROD_W'(recip);

  always_comb begin
    state_nxt     = state_r;
    pair_cnt_nxt  = pair_cnt_r;
    prev_code_nxt = prev_code_r;
    countdown_nxt = countdown_r;
    tol_nxt       = tol_r;
    rel_nxt       = rel_r;
    bits_nxt      = bits_r;
    idx_nxt       = idx_r;
    rd_vld_nxt    = 1'b0;
    sum_nxt       = sum_r;
    mean_nxt      = mean_r;
    acc_nxt       = acc_r;
    out_valid_nxt = 1'b0;
    out_word_nxt  = out_word_r;

    if (cfg_we) begin
      unique case (cfg_index)
        REG_TOLERANCE: tol_nxt = cfg_data[14:0];
        REG_RELEASE:   rel_nxt = cfg_data;
        default:       ;
      endcase
    end

    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          if (in_word.op) begin
            if (countdown_r != 16'd0) begin
              countdown_nxt = countdown_r - 16'd1;
              if (countdown_r == 16'd1) begin
                prev_code_nxt   = '0;
                out_valid_nxt   = 1'b1;
                out_word_nxt    = '{code: '0, is_release: 1'b1};
              end
            end
          end else if (!in_word.frame_end) begin
            pair_cnt_nxt = count_new;
          end else begin
            pair_cnt_nxt = '0;
            idx_nxt      = '0;
            sum_nxt      = '0;
            if (count_new == LONG_PAIRS) begin
              bits_nxt = LONG_BITS;
              if (CNT_W'(LONG_BITS) <= CNT_W'(PAIR_SLOTS)) begin
                state_nxt = ST_SUM;
              end
            end else if (count_new == SHORT_PAIRS) begin
              bits_nxt = SHORT_BITS;
              if (CNT_W'(SHORT_BITS) <= CNT_W'(PAIR_SLOTS)) begin
                state_nxt = ST_SUM;
              end
            end
          end
        end
      end
      ST_SUM: begin
        if (idx_r < bits_r) begin
          idx_nxt    = idx_r + 1'b1;
          rd_vld_nxt = 1'b1;
        end
        if (rd_vld_r) begin
          sum_nxt = sum_r + SUM_W'(pair_t);
        end else if (idx_r == bits_r) begin
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        mean_nxt  = mean_prod[RECIP_SHIFT +: MEAN_W];
        idx_nxt   = '0;
        acc_nxt   = '0;
        state_nxt = ST_CHECK;
      end
      ST_CHECK: begin
        if (rd_vld_r && pair_bad) begin
          state_nxt = ST_IDLE;
        end else begin
          if (idx_r < bits_r) begin
            idx_nxt    = idx_r + 1'b1;
            rd_vld_nxt = 1'b1;
          end
          if (rd_vld_r) begin
            acc_nxt = {acc_r[CODE_W-2:0], pair_bit};
          end else if (idx_r == bits_r) begin
            state_nxt = ST_DONE;
          end
        end
      end
      ST_DONE: begin
        state_nxt     = ST_IDLE;
        countdown_nxt = rel_r;
        if (acc_r != prev_code_r) begin
          prev_code_nxt = acc_r;
          out_valid_nxt = 1'b1;
          out_word_nxt  = '{code: acc_r, is_release: 1'b0};
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      pair_cnt_r  <= '0;
      prev_code_r <= '0;
      countdown_r <= '0;
      tol_r       <= TOL_RESET;
      rel_r       <= REL_RESET;
      rd_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pair_cnt_r  <= pair_cnt_nxt;
      prev_code_r <= prev_code_nxt;
      countdown_r <= countdown_nxt;
      tol_r       <= tol_nxt;
      rel_r       <= rel_nxt;
      rd_vld_r    <= rd_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
    bits_r     <= bits_nxt;
    idx_r      <= idx_nxt;
    sum_r      <= sum_nxt;
    mean_r     <= mean_nxt;
    acc_r      <= acc_nxt;
    out_word_r <= out_word_nxt;
  end

  assign busy      = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

endmodule
